### hw/rtl/ttrr_pkg.sv
// Shared constants, codes and controller/datapath interface types for the task table.
package ttrr_pkg;

    localparam int MAX_TASKS = 64;
    localparam int SLOT_W    = $clog2(MAX_TASKS);
    localparam int CNT_W     = $clog2(MAX_TASKS + 1);
    localparam int ID_W      = 31;

    // Operation codes
    localparam logic [2:0] OP_ADD       = 3'd0;
    localparam logic [2:0] OP_KILL      = 3'd1;
    localparam logic [2:0] OP_WAKE      = 3'd2;
    localparam logic [2:0] OP_SLEEP     = 3'd3;
    localparam logic [2:0] OP_QUERY     = 3'd4;
    localparam logic [2:0] OP_SLEEP_ALL = 3'd5;
    localparam logic [2:0] OP_PICK      = 3'd6;

    // Query status codes
    localparam logic [1:0] ST_SLEEPING = 2'd0;
    localparam logic [1:0] ST_AWAKE    = 2'd1;
    localparam logic [1:0] ST_ABSENT   = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_SEARCH,
        S_MOVE,
        S_CLEAR,
        S_PICK,
        S_FINISH
    } state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic latch;        // capture input word, clear result
        logic do_add;       // place new task on top if room
        logic fail_query;   // mark query result absent
        logic scan_first;   // start linear walk at slot 0
        logic pick_first;   // start pick walk at cursor, or slot 0 if cursor is past the top
        logic scan_step;    // advance linear walk
        logic pick_step;    // advance pick walk, wrapping
        logic found;        // act on the matched slot
        logic kill_top;     // drop top, fetch top entry
        logic move;         // write fetched top entry into hole
        logic clear_step;   // clear awake mark, advance
        logic set_ok;       // flag success
        logic pick_hit;     // record picked task
        logic out_load;     // hand result to output register
    } cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic [2:0] op;
        logic       empty;
        logic       id_match;
        logic       at_top;
        logic       awake;
        logic       pick_last;
        logic       out_free;
    } stat_t;

endpackage

### hw/rtl/ttrr_ctrl.sv
// Controller state machine sequencing each operation over the task table.
module ttrr_ctrl
    import ttrr_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  stat_t stat,
    output cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;

    // Hold state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_START;
                end
            end
            S_START:
            begin
                case (stat.op)
                    OP_KILL, OP_WAKE, OP_SLEEP, OP_QUERY:
                    begin
                        state_next = stat.empty ? S_FINISH : S_SEARCH;
                    end
                    OP_SLEEP_ALL:
                    begin
                        state_next = stat.empty ? S_FINISH : S_CLEAR;
                    end
                    OP_PICK:
                    begin
                        state_next = stat.empty ? S_FINISH : S_PICK;
                    end
                    default:
                    begin
                        state_next = S_FINISH;
                    end
                endcase
            end
            S_SEARCH:
            begin
                if (stat.id_match)
                begin
                    if (stat.op == OP_KILL && !stat.at_top)
                    begin
                        state_next = S_MOVE;
                    end
                    else
                    begin
                        state_next = S_FINISH;
                    end
                end
                else if (stat.at_top)
                begin
                    state_next = S_FINISH;
                end
            end
            S_MOVE:
            begin
                state_next = S_FINISH;
            end
            S_CLEAR:
            begin
                if (stat.at_top)
                begin
                    state_next = S_FINISH;
                end
            end
            S_PICK:
            begin
                if (stat.awake || stat.pick_last)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (stat.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Commands
    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready  = 1'b1;
                cmd.latch = in_valid;
            end
            S_START:
            begin
                case (stat.op)
                    OP_ADD:
                    begin
                        cmd.do_add = 1'b1;
                    end
                    OP_KILL, OP_WAKE, OP_SLEEP, OP_QUERY:
                    begin
                        cmd.scan_first = !stat.empty;
                        cmd.fail_query = stat.empty && (stat.op == OP_QUERY);
                    end
                    OP_SLEEP_ALL:
                    begin
                        cmd.set_ok     = 1'b1;
                        cmd.scan_first = !stat.empty;
                    end
                    OP_PICK:
                    begin
                        cmd.pick_first = !stat.empty;
                    end
                    default:
                    begin
                        cmd.set_ok = 1'b0;
                    end
                endcase
            end
            S_SEARCH:
            begin
                if (stat.id_match)
                begin
                    cmd.found    = 1'b1;
                    cmd.kill_top = (stat.op == OP_KILL);
                end
                else if (stat.at_top)
                begin
                    cmd.fail_query = (stat.op == OP_QUERY);
                end
                else
                begin
                    cmd.scan_step = 1'b1;
                end
            end
            S_MOVE:
            begin
                cmd.move = 1'b1;
            end
            S_CLEAR:
            begin
                cmd.clear_step = 1'b1;
            end
            S_PICK:
            begin
                if (stat.awake)
                begin
                    cmd.pick_hit = 1'b1;
                end
                else if (!stat.pick_last)
                begin
                    cmd.pick_step = 1'b1;
                end
            end
            S_FINISH:
            begin
                cmd.out_load = stat.out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

### hw/rtl/ttrr_dp.sv
// Datapath: task table memories, counters, walk pointers and result registers.
module ttrr_dp
    import ttrr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  cmd_t              cmd,
    output stat_t             stat,
    input  logic [2:0]        op,
    input  logic [ID_W-1:0]   task_id,
    input  logic              system_task,
    output logic              out_valid,
    input  logic              out_ready,
    output logic              ok,
    output logic [ID_W-1:0]   id_out,
    output logic [1:0]        status,
    output logic [SLOT_W-1:0] slot,
    output logic              system_out,
    output logic [CNT_W-1:0]  task_count
);

    // Table storage: {id, system mark} and awake mark
    logic [ID_W:0] id_mem [MAX_TASKS];
    logic          awake_mem [MAX_TASKS];

    logic [2:0]        op_reg;
    logic [ID_W-1:0]   tid_reg;
    logic              sys_reg;
    logic [CNT_W-1:0]  live_reg;
    logic [CNT_W-1:0]  live_next;
    logic [ID_W-1:0]   idc_reg;
    logic [CNT_W-1:0]  cursor_reg;
    logic [SLOT_W-1:0] scan_reg;
    logic [SLOT_W-1:0] scan_next;
    logic [SLOT_W-1:0] step_reg;
    logic [SLOT_W-1:0] hole_reg;
    logic [ID_W:0]     rd_word_reg;
    logic              rd_awake_reg;

    logic              res_ok_reg;
    logic [ID_W-1:0]   res_id_reg;
    logic [1:0]        res_status_reg;
    logic [SLOT_W-1:0] res_slot_reg;
    logic              res_sys_reg;

    logic              out_valid_reg;
    logic              ok_reg;
    logic [ID_W-1:0]   id_out_reg;
    logic [1:0]        status_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic              system_out_reg;
    logic [CNT_W-1:0]  count_reg;

    logic [CNT_W-1:0]  live_m1;
    logic [CNT_W-1:0]  scan_inc;
    logic [SLOT_W-1:0] pick_start;
    logic [SLOT_W-1:0] pick_wrap;
    logic [SLOT_W-1:0] rd_addr;
    logic              full;
    logic              flag_write;

    logic              idm_we;
    logic [SLOT_W-1:0] idm_addr;
    logic [ID_W:0]     idm_data;
    logic              awm_we;
    logic [SLOT_W-1:0] awm_addr;
    logic              awm_data;

    // Derived pointers
    assign live_m1    = CNT_W'(live_reg - 1'b1);
    assign scan_inc   = CNT_W'({1'b0, scan_reg} + 1'b1);
    assign full       = (live_reg == CNT_W'(MAX_TASKS));
    assign pick_start = (cursor_reg < live_reg) ? cursor_reg[SLOT_W-1:0] : '0;
    assign pick_wrap  = (scan_inc >= live_reg) ? '0 : scan_inc[SLOT_W-1:0];
    assign flag_write = cmd.found && (op_reg == OP_WAKE || op_reg == OP_SLEEP);

    // Walk pointer and read address
    always_comb
    begin
        scan_next = scan_reg;
        if (cmd.scan_first)
        begin
            scan_next = '0;
        end
        else if (cmd.pick_first)
        begin
            scan_next = pick_start;
        end
        else if (cmd.scan_step || cmd.clear_step)
        begin
            scan_next = scan_inc[SLOT_W-1:0];
        end
        else if (cmd.pick_step)
        begin
            scan_next = pick_wrap;
        end
        rd_addr = cmd.kill_top ? live_m1[SLOT_W-1:0] : scan_next;
    end

    // Memory write ports
    always_comb
    begin
        idm_we   = 1'b0;
        idm_addr = live_reg[SLOT_W-1:0];
        idm_data = {idc_reg, sys_reg};
        awm_we   = 1'b0;
        awm_addr = scan_reg;
        awm_data = 1'b0;
        if (cmd.do_add && !full)
        begin
            idm_we   = 1'b1;
            awm_we   = 1'b1;
            awm_addr = live_reg[SLOT_W-1:0];
            awm_data = 1'b1;
        end
        else if (cmd.move)
        begin
            idm_we   = 1'b1;
            idm_addr = hole_reg;
            idm_data = rd_word_reg;
            awm_we   = 1'b1;
            awm_addr = hole_reg;
            awm_data = rd_awake_reg;
        end
        else if (flag_write)
        begin
            awm_we   = 1'b1;
            awm_data = (op_reg == OP_WAKE);
        end
        else if (cmd.clear_step)
        begin
            awm_we = 1'b1;
        end
    end

    // Table memories with registered read
    always_ff @(posedge clk)
    begin
        if (idm_we)
        begin
            id_mem[idm_addr] <= idm_data;
        end
        rd_word_reg <= id_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (awm_we)
        begin
            awake_mem[awm_addr] <= awm_data;
        end
        rd_awake_reg <= awake_mem[rd_addr];
    end

    // Live count
    always_comb
    begin
        live_next = live_reg;
        if (cmd.do_add && !full)
        begin
            live_next = CNT_W'(live_reg + 1'b1);
        end
        else if (cmd.kill_top)
        begin
            live_next = live_m1;
        end
    end

    // Control state: counters and cursor
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            live_reg   <= '0;
            idc_reg    <= '0;
            cursor_reg <= '0;
        end
        else
        begin
            live_reg <= live_next;
            if (cmd.do_add && !full)
            begin
                idc_reg <= ID_W'(idc_reg + 1'b1);
            end
            if (cmd.pick_hit)
            begin
                cursor_reg <= scan_inc;
            end
        end
    end

    // Input capture, walk registers and result
    always_ff @(posedge clk)
    begin
        scan_reg <= scan_next;
        if (cmd.latch)
        begin
            op_reg         <= op;
            tid_reg        <= task_id;
            sys_reg        <= system_task;
            res_ok_reg     <= 1'b0;
            res_id_reg     <= '0;
            res_status_reg <= ST_SLEEPING;
            res_slot_reg   <= '0;
            res_sys_reg    <= 1'b0;
        end
        if (cmd.pick_first)
        begin
            step_reg <= '0;
        end
        else if (cmd.pick_step)
        begin
            step_reg <= SLOT_W'(step_reg + 1'b1);
        end
        if (cmd.kill_top)
        begin
            hole_reg <= scan_reg;
        end
        if (cmd.do_add && !full)
        begin
            res_ok_reg   <= 1'b1;
            res_id_reg   <= idc_reg;
            res_slot_reg <= live_reg[SLOT_W-1:0];
        end
        if (cmd.fail_query)
        begin
            res_status_reg <= ST_ABSENT;
        end
        if (cmd.found || cmd.set_ok)
        begin
            res_ok_reg <= 1'b1;
        end
        if (cmd.found && op_reg == OP_QUERY)
        begin
            res_status_reg <= rd_awake_reg ? ST_AWAKE : ST_SLEEPING;
        end
        if (cmd.pick_hit)
        begin
            res_ok_reg   <= 1'b1;
            res_id_reg   <= rd_word_reg[ID_W:1];
            res_slot_reg <= scan_reg;
            res_sys_reg  <= rd_word_reg[0];
        end
    end

    // Output register: hold word until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            ok_reg         <= res_ok_reg;
            id_out_reg     <= res_id_reg;
            status_reg     <= res_status_reg;
            slot_reg       <= res_slot_reg;
            system_out_reg <= res_sys_reg;
            count_reg      <= live_reg;
        end
    end

    // Status to controller
    assign stat.op        = op_reg;
    assign stat.empty     = (live_reg == '0);
    assign stat.id_match  = (rd_word_reg[ID_W:1] == tid_reg);
    assign stat.at_top    = ({1'b0, scan_reg} == live_m1);
    assign stat.awake     = rd_awake_reg;
    assign stat.pick_last = ({1'b0, step_reg} == live_m1);
    assign stat.out_free  = !out_valid_reg || out_ready;

    assign out_valid  = out_valid_reg;
    assign ok         = ok_reg;
    assign id_out     = id_out_reg;
    assign status     = status_reg;
    assign slot       = slot_reg;
    assign system_out = system_out_reg;
    assign task_count = count_reg;

`ifndef SYNTHESIS
    a_live_bound: assert property (@(posedge clk) disable iff (!rst_n)
        live_reg <= CNT_W'(MAX_TASKS))
        else $error("live count beyond table size");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || out_ready))
        else $error("result loaded over an untaken word");

    a_add_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.do_add && !full) |=> live_reg == CNT_W'($past(live_reg) + 1'b1))
        else $error("add did not grow the table");

    a_kill_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.kill_top |=> live_reg == CNT_W'($past(live_reg) - 1'b1))
        else $error("kill did not shrink the table");
`endif

endmodule

### hw/rtl/task_table_round_robin.sv
// Top level of the round-robin task table: controller plus datapath.
//
// Usage: one input word (op, task_id, system_task) is taken on in_valid/in_ready
// and exactly one result word (ok, id_out, status, slot, system_out, task_count)
// is returned on out_valid/out_ready, in order. Operations run one at a time.
// Operation flow, with N live tasks:
//   add, op 7, or any op on an empty table: no table walk
//   kill/wake/sleep/query: walk from slot 0 to the match (top if absent),
//     then a kill of any entry but the top moves the top entry into the hole
//   sleep all: walks all N; pick: walks from cursor to an awake entry, up to N
// The walks read one table entry per cycle through the registered read port of
// the table memory; a new word is taken once the previous one has reached the
// output register.
// Reset empties the table, zeroes the id counter and pick cursor; table
// memory contents are not cleared, and only entries of live slots are used.
// A stalled receiver holds the result word; the block still accepts the next
// input word and works on it, then waits until the output register is free.
module task_table_round_robin
    import ttrr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [2:0]        op,
    input  logic [ID_W-1:0]   task_id,
    input  logic              system_task,
    output logic              out_valid,
    input  logic              out_ready,
    output logic              ok,
    output logic [ID_W-1:0]   id_out,
    output logic [1:0]        status,
    output logic [SLOT_W-1:0] slot,
    output logic              system_out,
    output logic [CNT_W-1:0]  task_count
);

    cmd_t  cmd;
    stat_t stat;

    // Sequencer
    ttrr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Table and result path
    ttrr_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .op          (op),
        .task_id     (task_id),
        .system_task (system_task),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .ok          (ok),
        .id_out      (id_out),
        .status      (status),
        .slot        (slot),
        .system_out  (system_out),
        .task_count  (task_count)
    );

endmodule
